FILE: hw/rtl/drst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duplicate read signature table: shared types and constants
// Payload structs for the request and response transfers, the stored entry
// layout, hash multipliers and the sizing defaults of the table.
// ----------------------------------------------------------------------------
package drst_pkg;

   // table sizing defaults
   localparam int DEF_TABLE_SETS = 4096;
   localparam int DEF_TABLE_WAYS = 4;

   // key layout: chrom[63:55], start[54:24], span[23:0] per half
   localparam int CHROM_W = 9;
   localparam int START_W = 31;
   localparam int SPAN_W  = 24;
   localparam int HALF_W  = CHROM_W + START_W + SPAN_W;

   // set hash mixing constants
   localparam logic [63:0] HASH_MUL_A = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] HASH_MUL_B = 64'hBF58_476D_1CE4_E5B9;
   localparam int          HASH_SHR_A = 29;
   localparam int          HASH_SHR_B = 32;

   // set index reduction: radix-16 restoring remainder over the 64-bit hash
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = HALF_W / MOD_BITS;
   localparam int STEP_W    = $clog2(MOD_STEPS);

   typedef struct packed {
      logic                 action;
      logic [CHROM_W-1:0]   read_chrom;
      logic [START_W-1:0]   read_start;
      logic [SPAN_W-1:0]    read_span;
      logic [CHROM_W-1:0]   mate_chrom;
      logic [START_W-1:0]   mate_start;
      logic [SPAN_W-1:0]    mate_span;
      logic [31:0]          read_number;
      logic [31:0]          quality_sum;
   } req_payload_type;

   typedef struct packed {
      logic        is_duplicate;
      logic        became_best;
      logic        keep_read;
      logic        set_overflow;
      logic [31:0] duplicate_total;
   } rsp_payload_type;

   // one way of a set
   typedef struct packed {
      logic              valid;
      logic [HALF_W-1:0] key_high;
      logic [HALF_W-1:0] key_low;
      logic [31:0]       number;
      logic [31:0]       quality;
   } entry_type;

   // action codes
   localparam logic ACT_RECORD = 1'b0;
   localparam logic ACT_CHECK  = 1'b1;

endpackage

FILE: hw/rtl/duplicate_read_signature_table.sv
`timescale 1ns / 1ps
// The response strobe follows the start transfer through the states MUL, MIX,
// MUL, MIX, MOD, READ, MATCH and UPDATE. One request is taken at a time; busy
// stays high through the two 64-bit multiplies on one 32x32 multiplier and the
// 16-step set index remainder. Reset: synchronous; afterwards a clearing pass writes
// every set, one per cycle, with busy held high. Responses cannot be stalled.
// ----------------------------------------------------------------------------
// Duplicate read signature table
// Set-associative table keyed by the 128-bit read/mate signature. Record
// inserts or updates the best-quality keeper, check reports whether this read
// is the keeper. Each set lives in one memory row, read-modified-written.
// ----------------------------------------------------------------------------
module duplicate_read_signature_table #(
   parameter int TABLE_SETS = drst_pkg::DEF_TABLE_SETS,
   parameter int TABLE_WAYS = drst_pkg::DEF_TABLE_WAYS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  drst_pkg::req_payload_type req_item,
   output logic                      rsp_valid,
   output drst_pkg::rsp_payload_type rsp_item
);
   import drst_pkg::*;

   localparam int SET_W = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
   localparam int WAY_W = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
   localparam int REM_W = $clog2(TABLE_SETS) + 2;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_MIX    = 3'd3;
   localparam logic [2:0] ST_MOD    = 3'd4;
   localparam logic [2:0] ST_READ   = 3'd5;
   localparam logic [2:0] ST_MATCH  = 3'd6;
   localparam logic [2:0] ST_UPDATE = 3'd7;

   // control registers
   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              pass_ff, pass_in;
   logic [SET_W-1:0]  clr_ff, clr_in;
   logic [31:0]       dup_count_ff, dup_count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic              action_ff, action_in;
   logic [HALF_W-1:0] lo_ff, lo_in;
   logic [HALF_W-1:0] hi_ff, hi_in;
   logic [31:0]       number_ff, number_in;
   logic [31:0]       quality_ff, quality_in;
   logic [63:0]       mul_a_ff, mul_a_in;
   logic [63:0]       prod_ff, prod_in;
   logic [63:0]       acc_ff, acc_in;
   logic [63:0]       div_ff, div_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [SET_W-1:0]  set_ff, set_in;
   logic              hit_ff, hit_in;
   logic [WAY_W-1:0]  hit_way_ff, hit_way_in;
   logic              free_ff, free_in;
   logic [WAY_W-1:0]  free_way_ff, free_way_in;
   rsp_payload_type   rsp_item_ff, rsp_item_in;

   // set memory
   entry_type [TABLE_WAYS-1:0] set_mem [TABLE_SETS];
   entry_type [TABLE_WAYS-1:0] rd_row_ff;
   entry_type [TABLE_WAYS-1:0] mem_wdata;
   logic                       mem_we;
   logic [SET_W-1:0]           mem_addr;

   // shared datapath helpers
   logic [31:0]      op_a, op_b;
   logic [63:0]      mul_prod;
   logic [63:0]      mul_b;
   logic [63:0]      mix_x;
   logic [REM_W-1:0] rem_v;
   logic [63:0]      div_v;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // 32x32 partial products of the 64-bit product mod 2^64
   assign mul_b = pass_ff ? HASH_MUL_B : HASH_MUL_A;

   always_comb begin
      case (step_ff[1:0])
         2'd1: begin
            op_a = mul_a_ff[31:0];
            op_b = mul_b[63:32];
         end
         2'd2: begin
            op_a = mul_a_ff[63:32];
            op_b = mul_b[31:0];
         end
         default: begin
            op_a = mul_a_ff[31:0];
            op_b = mul_b[31:0];
         end
      endcase
   end

   assign mul_prod = {32'h0, op_a} * {32'h0, op_b};

   // first mixing round
   always_comb begin
      mix_x = {hi_ff, lo_ff} [HALF_W-1:0] ^ acc_ff;
      mix_x = lo_ff ^ acc_ff;
      mix_x = mix_x ^ (mix_x >> HASH_SHR_A);
   end

   // four remainder steps per cycle
   always_comb begin
      rem_v = rem_ff;
      div_v = div_ff;
      for (int i = 0; i < MOD_BITS; i++) begin
         rem_v = {rem_v[REM_W-2:0], div_v[63]};
         div_v = {div_v[62:0], 1'b0};
         if (rem_v >= REM_W'(TABLE_SETS)) begin
            rem_v = rem_v - REM_W'(TABLE_SETS);
         end
      end
   end

   // sequencer
   always_comb begin
      entry_type fresh;
      logic      found;
      logic      empty;
      logic      do_write;

      state_in     = state_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      clr_in       = clr_ff;
      dup_count_in = dup_count_ff;
      rsp_valid_in = 1'b0;
      action_in    = action_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      number_in    = number_ff;
      quality_in   = quality_ff;
      mul_a_in     = mul_a_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      set_in       = set_ff;
      hit_in       = hit_ff;
      hit_way_in   = hit_way_ff;
      free_in      = free_ff;
      free_way_in  = free_way_ff;
      rsp_item_in  = rsp_item_ff;
      mem_we       = 1'b0;
      mem_addr     = set_ff;
      mem_wdata    = rd_row_ff;
      found        = 1'b0;
      empty        = 1'b0;
      do_write     = 1'b0;

      fresh.valid    = 1'b1;
      fresh.key_high = hi_ff;
      fresh.key_low  = lo_ff;
      fresh.number   = number_ff;
      fresh.quality  = quality_ff;

      case (state_ff)
         // invalidate every set after reset
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            if (clr_ff == SET_W'(TABLE_SETS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         // take a request and pack its key
         ST_IDLE: begin
            if (start) begin
               action_in  = req_item.action;
               lo_in      = {req_item.read_chrom, req_item.read_start, req_item.read_span};
               hi_in      = {req_item.mate_chrom, req_item.mate_start, req_item.mate_span};
               number_in  = req_item.read_number;
               quality_in = req_item.quality_sum;
               mul_a_in   = {req_item.mate_chrom, req_item.mate_start, req_item.mate_span};
               pass_in    = 1'b0;
               step_in    = '0;
               state_in   = ST_MUL;
            end
         end

         // low product first, then the two cross terms into the upper word
         ST_MUL: begin
            prod_in = mul_prod;
            if (step_ff[1:0] == 2'd1) begin
               acc_in = prod_ff;
            end else if (step_ff[1:0] != 2'd0) begin
               acc_in = acc_ff + {prod_ff[31:0], 32'h0};
            end
            if (step_ff[1:0] == 2'd3) begin
               step_in  = '0;
               state_in = ST_MIX;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         // xor-shift rounds between and after the multiplies
         ST_MIX: begin
            if (!pass_ff) begin
               mul_a_in = mix_x;
               pass_in  = 1'b1;
               state_in = ST_MUL;
            end else begin
               div_in   = acc_ff ^ (acc_ff >> HASH_SHR_B);
               rem_in   = '0;
               state_in = ST_MOD;
            end
         end

         // hash modulo set count
         ST_MOD: begin
            rem_in = rem_v;
            div_in = div_v;
            if (step_ff == STEP_W'(MOD_STEPS - 1)) begin
               set_in   = rem_v[SET_W-1:0];
               step_in  = '0;
               state_in = ST_READ;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         // set row read issued at this edge
         ST_READ: begin
            state_in = ST_MATCH;
         end

         // first matching way and lowest free way
         ST_MATCH: begin
            hit_in      = 1'b0;
            hit_way_in  = '0;
            free_in     = 1'b0;
            free_way_in = '0;
            for (int w = 0; w < TABLE_WAYS; w++) begin
               if (rd_row_ff[w].valid) begin
                  if (!found && rd_row_ff[w].key_low == lo_ff &&
                      rd_row_ff[w].key_high == hi_ff) begin
                     found      = 1'b1;
                     hit_way_in = WAY_W'(w);
                  end
               end else if (!empty) begin
                  empty       = 1'b1;
                  free_way_in = WAY_W'(w);
               end
            end
            hit_in   = found;
            free_in  = empty;
            state_in = ST_UPDATE;
         end

         // modify the row, write it back when it changed, and report
         ST_UPDATE: begin
            rsp_item_in = '0;
            if (action_ff == ACT_RECORD) begin
               if (hit_ff) begin
                  rsp_item_in.is_duplicate = 1'b1;
                  if (dup_count_ff != '1) begin
                     dup_count_in = dup_count_ff + 1'b1;
                  end
                  if (quality_ff > rd_row_ff[hit_way_ff].quality) begin
                     mem_wdata[hit_way_ff].number  = number_ff;
                     mem_wdata[hit_way_ff].quality = quality_ff;
                     rsp_item_in.became_best       = 1'b1;
                     do_write                      = 1'b1;
                  end
               end else if (free_ff) begin
                  mem_wdata[free_way_ff]  = fresh;
                  rsp_item_in.became_best = 1'b1;
                  do_write                = 1'b1;
               end else begin
                  rsp_item_in.set_overflow = 1'b1;
               end
            end else if (hit_ff) begin
               rsp_item_in.keep_read = (rd_row_ff[hit_way_ff].number == number_ff) &&
                                       (rd_row_ff[hit_way_ff].quality == quality_ff);
            end
            rsp_item_in.duplicate_total = dup_count_in;
            mem_we       = do_write;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // set memory, registered read captured in the READ state
   always_ff @(posedge clock) begin
      if (mem_we) begin
         set_mem[mem_addr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         rd_row_ff <= set_mem[mem_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         pass_ff      <= 1'b0;
         clr_ff       <= '0;
         dup_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         clr_ff       <= clr_in;
         dup_count_ff <= dup_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      number_ff   <= number_in;
      quality_ff  <= quality_in;
      mul_a_ff    <= mul_a_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      set_ff      <= set_in;
      hit_ff      <= hit_in;
      hit_way_ff  <= hit_way_in;
      free_ff     <= free_in;
      free_way_ff <= free_way_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

FILE: hw/rtl/drst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duplicate read signature table: port checker
// Watches the request and response ports and flags a request not followed by busy,
// a long response strobe, mixed record and check outcomes, or a zero duplicate total.
// ----------------------------------------------------------------------------
module drst_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input drst_pkg::rsp_payload_type rsp_item
);

   // an accepted request keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer not followed by busy");

   // a response is a single-cycle strobe
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // a keep result comes from a check and carries no record flags
   a_check_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.keep_read) |->
         (!rsp_item.is_duplicate && !rsp_item.became_best && !rsp_item.set_overflow))
      else $error("keep_read together with record flags");

   // a dropped insert is neither a duplicate nor a new keeper
   a_overflow_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.set_overflow) |->
         (!rsp_item.is_duplicate && !rsp_item.became_best))
      else $error("set_overflow together with hit or insert");

   // a duplicate always leaves a nonzero running count
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.is_duplicate) |-> (rsp_item.duplicate_total != 32'h0))
      else $error("duplicate reported with zero total");

endmodule

bind duplicate_read_signature_table drst_checker u_drst_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
